// ----- sv/cfr_pkg.sv -----
// cfr_pkg: shared types and constants of the CAN frame reassembler
// no dependencies; imported by cfr_ctrl, cfr_merge, can_frame_reassembler and the testbench
`default_nettype none

package cfr_pkg;

  // message store geometry
  localparam int unsigned MaxFrames = 4;
  localparam int unsigned AddrW     = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned WordW     = 64;
  localparam int unsigned BytesW    = WordW / 8;

  // field widths
  localparam int unsigned IdW    = 29;
  localparam int unsigned LenW   = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned CfgIdxW = 1;

  // identifier that no frame can follow
  localparam logic [IdW-1:0] IdNone = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBaseId     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameCount = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KindAccept = 2'd0,
    KindReject = 2'd1,
    KindWord   = 2'd2
  } kind_e;

  // one memory operation travelling from the sequencer to the merge stage
  typedef struct packed {
    logic              wr;    // read-modify-write of a frame
    logic              res;   // produces a result
    kind_e             kind;
    logic [AddrW-1:0]  addr;
    logic [BytesW-1:0] be;
    logic [WordW-1:0]  data;
    logic [ErrW-1:0]   err;
    logic              last;
  } op_t;

endpackage

`default_nettype wire

// ----- sv/cfr_ram.sv -----
// cfr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module cfr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/cfr_ctrl.sv -----
// cfr_ctrl: frame check, id and reject tracking, message word sequencer
// depends on cfr_pkg
`default_nettype none

module cfr_ctrl
  import cfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IdW-1:0]   base_id_i,
  input  wire logic [CntW-1:0]  frame_count_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [IdW-1:0]   frame_id_i,
  input  wire logic [LenW-1:0]  frame_len_i,
  input  wire logic [WordW-1:0] frame_data_i,
  input  wire logic             issue_ok_i,
  output logic                  op_valid_o,
  output op_t                   op_o
);

  logic [IdW-1:0]   prev_id_q, prev_id_d;
  logic [ErrW-1:0]  rej_cnt_q, rej_cnt_d;
  logic             emit_q, emit_d;
  logic [AddrW-1:0] emit_idx_q, emit_idx_d;
  logic [AddrW-1:0] emit_end_q, emit_end_d;

  logic [CntW-1:0]  cnt_sat;
  logic [LenW-1:0]  len_sat;
  logic [IdW:0]     id_end;
  logic [IdW:0]     prev_next;
  logic [IdW-1:0]   diff;
  logic             ok;
  logic             is_last;
  logic             accept;
  logic [BytesW-1:0] be;

  // saturate count and length
  always_comb begin
    cnt_sat = (32'(frame_count_i) > MaxFrames) ? CntW'(MaxFrames) : frame_count_i;
    len_sat = (frame_len_i > LenW'(BytesW)) ? LenW'(BytesW) : frame_len_i;
  end

  // frame check, compared without wrap
  always_comb begin
    id_end    = {1'b0, base_id_i} + (IdW+1)'(cnt_sat);
    prev_next = {1'b0, prev_id_q} + (IdW+1)'(1);
    diff      = frame_id_i - base_id_i;
    ok        = (frame_id_i >= base_id_i) && ({1'b0, frame_id_i} < id_end) &&
                ((frame_id_i == base_id_i) || ({1'b0, frame_id_i} == prev_next));
    is_last   = (diff[CntW-1:0] + CntW'(1)) == cnt_sat;
  end

  // byte enables from length
  always_comb begin
    for (int i = 0; i < BytesW; i++) begin
      be[i] = LenW'(i) < len_sat;
    end
  end

  assign in_ready_o = !emit_q && issue_ok_i;
  assign accept     = in_valid_i && in_ready_o;

  // operation issue: emission of message words takes priority over frames
  always_comb begin
    prev_id_d  = prev_id_q;
    rej_cnt_d  = rej_cnt_q;
    emit_d     = emit_q;
    emit_idx_d = emit_idx_q;
    emit_end_d = emit_end_q;
    op_valid_o = 1'b0;
    op_o       = '0;
    if (emit_q) begin
      op_valid_o = issue_ok_i;
      op_o.wr    = 1'b0;
      op_o.res   = 1'b1;
      op_o.kind  = KindWord;
      op_o.addr  = emit_idx_q;
      op_o.err   = rej_cnt_q;
      op_o.last  = emit_idx_q == emit_end_q;
      if (issue_ok_i) begin
        emit_idx_d = emit_idx_q + AddrW'(1);
        if (emit_idx_q == emit_end_q) begin
          emit_d = 1'b0;
        end
      end
    end else if (accept) begin
      op_valid_o = 1'b1;
      op_o.last  = 1'b1;
      op_o.be    = be;
      op_o.data  = frame_data_i;
      op_o.addr  = diff[AddrW-1:0];
      if (ok) begin
        prev_id_d = frame_id_i;
        op_o.wr   = 1'b1;
        op_o.res  = !is_last;
        op_o.kind = KindAccept;
        op_o.err  = rej_cnt_q;
        if (is_last) begin
          emit_d     = 1'b1;
          emit_idx_d = '0;
          emit_end_d = AddrW'(cnt_sat - CntW'(1));
        end
      end else begin
        rej_cnt_d = rej_cnt_q + ErrW'(1);
        op_o.wr   = 1'b0;
        op_o.res  = 1'b1;
        op_o.kind = KindReject;
        op_o.err  = rej_cnt_q + ErrW'(1);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_id_q  <= IdNone;
      rej_cnt_q  <= '0;
      emit_q     <= 1'b0;
      emit_idx_q <= '0;
      emit_end_q <= '0;
    end else begin
      prev_id_q  <= prev_id_d;
      rej_cnt_q  <= rej_cnt_d;
      emit_q     <= emit_d;
      emit_idx_q <= emit_idx_d;
      emit_end_q <= emit_end_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cfr_merge.sv -----
// cfr_merge: read data stage, byte merge, write-back forwarding, result register
// depends on cfr_pkg
`default_nettype none

module cfr_merge
  import cfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             op_valid_i,
  input  wire op_t              op_i,
  output logic                  issue_ok_o,
  input  wire logic [WordW-1:0] rdata_i,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output logic [WordW-1:0]      wdata_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [IdxW-1:0]       word_index_o,
  output logic [WordW-1:0]      message_word_o,
  output logic [ErrW-1:0]       error_count_o,
  output logic                  last_word_o
);

  logic                 s1_v_q, s1_v_d;
  op_t                  s1_q;
  logic                 fwd_q;
  logic [WordW-1:0]     fwd_data_q;
  logic [MaxFrames-1:0] vld_q, vld_d;
  logic                 out_v_q, out_v_d;
  kind_e                out_kind_q;
  logic [IdxW-1:0]      out_idx_q;
  logic [WordW-1:0]     out_word_q;
  logic [ErrW-1:0]      out_err_q;
  logic                 out_last_q;

  logic                 s1_fire;
  logic                 load;
  logic [WordW-1:0]     cur;
  logic [WordW-1:0]     merged;

  // stage advance: ops without a result need no output space
  assign s1_fire    = s1_v_q && (!s1_q.res || !out_v_q || out_ready_i);
  assign issue_ok_o = !s1_v_q || s1_fire;
  assign load       = s1_fire && s1_q.res;

  // current word: forwarded write, stored word, or reset value
  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (vld_q[s1_q.addr]) begin
      cur = rdata_i;
    end else begin
      cur = '0;
    end
    for (int i = 0; i < BytesW; i++) begin
      merged[i*8 +: 8] = s1_q.be[i] ? s1_q.data[i*8 +: 8] : cur[i*8 +: 8];
    end
  end

  // write-back
  assign we_o    = s1_fire && s1_q.wr;
  assign waddr_o = s1_q.addr;
  assign wdata_o = merged;

  always_comb begin
    vld_d = vld_q;
    if (we_o) begin
      vld_d[s1_q.addr] = 1'b1;
    end
    s1_v_d = s1_v_q;
    if (op_valid_i) begin
      s1_v_d = 1'b1;
    end else if (s1_fire) begin
      s1_v_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      vld_q   <= '0;
      out_v_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      vld_q   <= vld_d;
      out_v_q <= out_v_d;
      if (op_valid_i) begin
        fwd_q <= we_o && (op_i.addr == s1_q.addr);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (op_valid_i) begin
      s1_q       <= op_i;
      fwd_data_q <= merged;
    end
    if (load) begin
      out_kind_q <= s1_q.kind;
      out_err_q  <= s1_q.err;
      out_last_q <= s1_q.last;
      if (s1_q.kind == KindWord) begin
        out_idx_q  <= IdxW'(s1_q.addr);
        out_word_q <= cur;
      end else begin
        out_idx_q  <= '0;
        out_word_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_kind_q;
  assign word_index_o   = out_idx_q;
  assign message_word_o = out_word_q;
  assign error_count_o  = out_err_q;
  assign last_word_o    = out_last_q;

endmodule

`default_nettype wire

// ----- sv/can_frame_reassembler.sv -----
// can_frame_reassembler: top level, configuration registers and module wiring
// depends on cfr_pkg, cfr_ram, cfr_ctrl, cfr_merge
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one received CAN frame per
//   request (frame_id_i, frame_len_i, frame_data_i). Output channel
//   out_valid_o/out_ready_i carries results: one per rejected or accepted
//   frame, or one per message word (up to four) for the last frame of a
//   message, in word order, last_word_o marking the final one.
//   The result of a frame passes the merge stage register, then the output
//   register. Frames are taken one per cycle while in_ready_o is high; a
//   completing frame blocks input while its words (frame_count, at most four)
//   are read out of the store over its single read port, one word per cycle
//   while the merge stage does not stall.
//   The store is a 4 x 64 bit RAM updated by read-modify-write; a write that
//   hits the entry read in the same cycle is forwarded.
//   Reset clears the store (per-entry valid bits), sets the previous id to
//   all ones and the reject count to zero; no clearing pass is needed.
//   When the receiver stalls, one result waits in the output register and one
//   operation in the merge stage; further frames wait on in_ready_o.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and are meant for idle periods; index 0 base id, 1 frame count.
`default_nettype none

module can_frame_reassembler
  import cfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [IdW-1:0]     cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [IdW-1:0]     frame_id_i,
  input  wire logic [LenW-1:0]    frame_len_i,
  input  wire logic [WordW-1:0]   frame_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [IdxW-1:0]         word_index_o,
  output logic [WordW-1:0]        message_word_o,
  output logic [ErrW-1:0]         error_count_o,
  output logic                    last_word_o
);

  logic [IdW-1:0]   base_id_q;
  logic [CntW-1:0]  frame_count_q;
  logic             issue_ok;
  logic             op_valid;
  op_t              op;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordW-1:0] wdata;
  logic [WordW-1:0] rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q     <= '0;
      frame_count_q <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBaseId:     base_id_q     <= cfg_wdata_i;
        CfgFrameCount: frame_count_q <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  cfr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_id_i     (base_id_q),
    .frame_count_i (frame_count_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_id_i    (frame_id_i),
    .frame_len_i   (frame_len_i),
    .frame_data_i  (frame_data_i),
    .issue_ok_i    (issue_ok),
    .op_valid_o    (op_valid),
    .op_o          (op)
  );

  cfr_ram #(
    .Width (WordW),
    .Depth (MaxFrames)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (op_valid),
    .raddr_i (op.addr),
    .rdata_o (rdata)
  );

  cfr_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op),
    .issue_ok_o     (issue_ok),
    .rdata_i        (rdata),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .word_index_o   (word_index_o),
    .message_word_o (message_word_o),
    .error_count_o  (error_count_o),
    .last_word_o    (last_word_o)
  );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench: self-checking bench for the CAN frame reassembler
// depends on cfr_pkg and can_frame_reassembler; predicts every result in a small tracker class

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned RandomItems = 350;
  localparam int unsigned ReportLimit = 10;

  // one result as seen on the output channel
  typedef struct packed {
    kind_e            kind;
    logic [IdxW-1:0]  index;
    logic [WordW-1:0] word;
    logic [ErrW-1:0]  errors;
    logic             last;
  } result_t;

  // reassembly predictor: own copy of registers, message store and counters
  class reassembly_tracker;
    logic [IdW-1:0]   base_id;
    logic [CntW-1:0]  frame_count;
    logic [WordW-1:0] store [MaxFrames];
    logic [IdW-1:0]   prev_id;
    logic [ErrW-1:0]  reject_total;
    result_t          due_results [$];
    int unsigned      mismatches;

    function new();
      base_id      = '0;
      frame_count  = CntW'(1);
      foreach (store[i]) store[i] = '0;
      prev_id      = IdNone;
      reject_total = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [IdW-1:0] value);
      case (idx)
        CfgBaseId:     base_id = value;
        CfgFrameCount: frame_count = value[CntW-1:0];
        default: ;
      endcase
    endfunction

    function void push(kind_e kind, int unsigned index, logic [WordW-1:0] word, logic last);
      result_t r;
      r.kind   = kind;
      r.index  = IdxW'(index);
      r.word   = word;
      r.errors = reject_total;
      r.last   = last;
      due_results.push_back(r);
    endfunction

    // work out the results of one accepted frame request
    function void note_frame(logic [IdW-1:0] id, logic [LenW-1:0] len, logic [WordW-1:0] data);
      int unsigned      frames;
      int unsigned      nbytes;
      int unsigned      pos;
      logic [IdW:0]     id_end;
      logic [WordW-1:0] mask;
      frames = (frame_count > MaxFrames) ? MaxFrames : frame_count;
      nbytes = (len > BytesW) ? BytesW : len;
      id_end = {1'b0, base_id} + frames;
      // sum and successor are one bit wider, so nothing wraps
      if (id < base_id || {1'b0, id} >= id_end ||
          (id != base_id && {1'b0, id} != {1'b0, prev_id} + 1'b1)) begin
        reject_total++;
        push(KindReject, 0, '0, 1'b1);
        return;
      end
      mask = '0;
      for (int b = 0; b < nbytes; b++) mask[8*b +: 8] = 8'hFF;
      pos = id - base_id;
      store[pos] = (store[pos] & ~mask) | (data & mask);
      prev_id = id;
      if (pos + 1 != frames) begin
        push(KindAccept, 0, '0, 1'b1);
      end else begin
        for (int k = 0; k < frames; k++) push(KindWord, k, store[k], k == frames - 1);
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: kind %0d index %0d word %h errors %0d last %0b",
                   got.kind, got.index, got.word, got.errors, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.index !== want.index || got.word !== want.word ||
          got.errors !== want.errors || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("mismatch: expected kind %0d index %0d word %h errors %0d last %0b, got kind %0d index %0d word %h errors %0d last %0b",
                   want.kind, want.index, want.word, want.errors, want.last,
                   got.kind, got.index, got.word, got.errors, got.last);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = CfgBaseId;
  logic [IdW-1:0]     cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [IdW-1:0]     frame_id_i   = '0;
  logic [LenW-1:0]    frame_len_i  = '0;
  logic [WordW-1:0]   frame_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [1:0]         kind_o;
  logic [IdxW-1:0]    word_index_o;
  logic [WordW-1:0]   message_word_o;
  logic [ErrW-1:0]    error_count_o;
  logic               last_word_o;

  reassembly_tracker tracker = new();

  int unsigned burst_left   = 0;
  int unsigned frames_sent  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_pct    = 100;
  int unsigned ready_age    = 0;

  can_frame_reassembler u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_id_i     (frame_id_i),
    .frame_len_i    (frame_len_i),
    .frame_data_i   (frame_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .word_index_o   (word_index_o),
    .message_word_o (message_word_o),
    .error_count_o  (error_count_o),
    .last_word_o    (last_word_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // observe both channels at the edge
  always @(posedge clk_i) begin : observe
    result_t got;
    if (rst_ni && in_valid_i && in_ready_o)
      tracker.note_frame(frame_id_i, frame_len_i, frame_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind   = kind_e'(kind_o);
      got.index  = word_index_o;
      got.word   = message_word_o;
      got.errors = error_count_o;
      got.last   = last_word_o;
      tracker.check_result(got);
    end
  end

  // receiver stalls: ready rate switches among 100, 50 and 20 percent, each held for a random time
  always @(posedge clk_i) begin
    if (ready_age == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_pct = 100;
        1:       ready_pct = 50;
        default: ready_pct = 20;
      endcase
      ready_age = $urandom_range(20, 80);
    end else begin
      ready_age--;
    end
    out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [LenW-1:0] rand_len();
    if ($urandom_range(0, 9) == 0) return LenW'($urandom_range(9, 15));
    return LenW'($urandom_range(0, 8));
  endfunction

  function automatic logic [WordW-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // one frame request; bursts usually end with a random gap
  task automatic send_frame(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                            input logic [WordW-1:0] data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i   <= 1'b1;
    frame_id_i   <= id;
    frame_len_i  <= len;
    frame_data_i <= data;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    burst_left--;
    frames_sent++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (tracker.due_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write both registers while the block is idle
  task automatic set_config(input logic [IdW-1:0] base, input logic [IdW-1:0] count_word);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgBaseId;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    tracker.write_reg(CfgBaseId, base);
    cfg_idx_i   <= CfgFrameCount;
    cfg_wdata_i <= count_word;
    @(posedge clk_i);
    tracker.write_reg(CfgFrameCount, count_word);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [IdW-1:0]  cur_base;
    logic [CntW-1:0] cur_count;
    logic [31:0]     hi;
    int              cur_frames;
    int              phase_left;
    int unsigned     pick;
    int unsigned     random_start;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: base zero, single frame messages
    send_frame('0, 4'd8, '1);
    send_frame(IdW'(1), 4'd8, rand_data());
    send_frame('0, 4'd0, rand_data());

    // base at the top of the id range, sum beyond 29 bits
    set_config(29'h1FFF_FFFC, 29'd4);
    send_frame(29'h1FFF_FFFD, 4'd8, rand_data());
    send_frame(29'h1FFF_FFFC, 4'd3, 64'h0123_4567_89AB_CDEF);
    send_frame(29'h1FFF_FFFC, 4'd8, 64'hFEDC_BA98_7654_3210);
    send_frame(29'h1FFF_FFFD, 4'd15, 64'hA5A5_5A5A_C3C3_3C3C);
    send_frame(29'h1FFF_FFFF, 4'd8, rand_data());
    send_frame(29'h1FFF_FFFE, 4'd0, rand_data());
    send_frame(29'h1FFF_FFFE, 4'd8, rand_data());
    send_frame(29'h1FFF_FFFF, 4'd5, '1);
    // previous id is all ones now, identifier zero must not follow it
    send_frame('0, 4'd8, rand_data());

    // frame count zero rejects everything; upper write bits are don't care
    set_config('0, {26'h3FF_FFFF, 3'd0});
    send_frame('0, 4'd8, rand_data());

    // frame count above the store size saturates
    set_config(29'h100, 29'd7);
    send_frame(29'h100, 4'd8, rand_data());
    send_frame(29'h101, 4'd1, rand_data());
    send_frame(29'h104, 4'd8, rand_data());

    // id below a moved base is rejected although it follows the previous one
    set_config(29'h103, 29'h1FFF_FFFD);
    send_frame(29'h102, 4'd8, rand_data());
    send_frame(29'h103, 4'd8, rand_data());
    send_frame(29'h104, 4'd2, rand_data());
    send_frame(29'h105, 4'd9, rand_data());
    send_frame(29'h106, 4'd4, rand_data());

    // short message with partial writes over older bytes
    set_config(29'h20, 29'd2);
    send_frame(29'h20, 4'd9, rand_data());
    send_frame(29'h21, 4'd2, rand_data());

    // random phases
    cur_base = 29'h20;
    random_start = frames_sent;
    while (frames_sent - random_start < RandomItems) begin
      case ($urandom_range(0, 3))
        0:       cur_base = IdW'($urandom_range(0, 15));
        1:       cur_base = IdW'($urandom);
        2:       cur_base = IdNone - IdW'($urandom_range(0, 5));
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) cur_count = '0;
      else if (pick == 1) cur_count = CntW'($urandom_range(5, 7));
      else cur_count = CntW'($urandom_range(1, 4));
      hi = $urandom;
      set_config(cur_base, {hi[IdW-CntW-1:0], cur_count});
      cur_frames = (cur_count > MaxFrames) ? MaxFrames : ((cur_count == 0) ? 1 : cur_count);
      phase_left = $urandom_range(15, 40);
      while (phase_left > 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed message, now and then cut short or with a stray id
          for (int k = 0; k < cur_frames; k++) begin
            if ($urandom_range(0, 19) == 0)
              send_frame(cur_base + IdW'($urandom_range(0, 5)), rand_len(), rand_data());
            else
              send_frame(cur_base + IdW'(k), rand_len(), rand_data());
            phase_left--;
            if ($urandom_range(0, 15) == 0) break;
          end
        end else if (pick < 9) begin
          // noise around the base
          send_frame(cur_base + IdW'($urandom_range(0, 6)) - IdW'(1), rand_len(), rand_data());
          phase_left--;
        end else begin
          send_frame(IdW'($urandom), rand_len(), rand_data());
          phase_left--;
        end
      end
    end

    settle();
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cfr_pkg.sv
sv/cfr_ram.sv
sv/cfr_ctrl.sv
sv/cfr_merge.sv
sv/can_frame_reassembler.sv
verif/testbench.sv
